// ===== design/cspb_pkg.sv =====
// Shared types and constants for the cursor sprite blit unit.
package cspb_pkg;

    localparam int COORD_W  = 13;
    localparam int SPRW_W   = 7;
    localparam int DEPTH_W  = 3;
    localparam int BASE_W   = 28;
    localparam int ADDR_W   = 26;
    localparam int PIX_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SPRW_W-1:0]  RST_SPRITE_WIDTH  = 7'd16;
    localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [DEPTH_W-1:0] RST_BYTES_PER_PIX = 3'd1;

    // Depth codes after clamping to the legal range
    localparam logic [DEPTH_W-1:0] DEPTH_MIN = 3'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X        = 3'd0,
        CFG_ORIGIN_Y        = 3'd1,
        CFG_SPRITE_WIDTH    = 3'd2,
        CFG_SCREEN_WIDTH    = 3'd3,
        CFG_SCREEN_HEIGHT   = 3'd4,
        CFG_BYTES_PER_PIXEL = 3'd5,
        CFG_KEY_COLOR       = 3'd6,
        CFG_KEY_ENABLE      = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             last_pixel;
    } pix_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] fb_byte_address;
        logic [PIX_W-1:0]  write_data;
    } fb_write_t;

endpackage

// ===== design/cursor_sprite_blit_unit.sv =====
// Cursor sprite blit: color-keyed, screen-clipped pointer bitmap to framebuffer writes.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one bitmap pixel per
//   transfer, in raster order, with last_pixel set on the final pixel of the bitmap.
//   Output channel (out_valid / out_stall / out_data) carries one framebuffer write
//   (byte address and pixel bytes) for each pixel that lands on screen and is not
//   the key color. Off-screen and transparent pixels produce no transfer.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   eight registers; cfg_ready is always high. Write only while the unit is idle.
// Timing:
//   One pixel per cycle sustained unless in_stall holds it (a held result or a reload).
//   A pixel goes through the input register, then the result register, before it
//   can transfer. Every register write starts a reload of the row stride and row
//   base (first the stride, then the signed base multiply); in_stall is high
//   until the reload is done.
// Reset: async, active low; registers go to their defaults and counters to zero.
// Stall: a held result stays in the output register; the input stage keeps taking
//   pixels while it has room, and a pixel that makes no write never blocks.
module cursor_sprite_blit_unit
    import cspb_pkg::*;
#(
    parameter int MAX_SCREEN_DIM = 4096,
    parameter int MAX_SPRITE_DIM = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pix_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output fb_write_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CntW  = $clog2(MAX_SPRITE_DIM) + 1;
    localparam int ScrW  = $clog2(MAX_SCREEN_DIM) + 1;
    localparam int StrW  = ScrW + DEPTH_W;
    localparam int PosW  = COORD_W + 1;
    localparam int XoffW = PosW + DEPTH_W;
    localparam int CmpW  = 32;
    localparam int ProdW = (PosW + StrW + 1 > BASE_W) ? PosW + StrW + 1 : BASE_W;

    // Configuration registers
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic [SPRW_W-1:0]         sprite_width_reg;
    logic [COORD_W-1:0]        screen_width_reg;
    logic [COORD_W-1:0]        screen_height_reg;
    logic [DEPTH_W-1:0]        bytes_per_pixel_reg;
    logic [PIX_W-1:0]          key_color_reg;
    logic                      key_enable_reg;

    // Position state
    logic [CntW-1:0]   col_reg, col_next;
    logic [CntW-1:0]   row_reg, row_next;
    logic [BASE_W-1:0] row_base_reg, row_base_next;
    logic [BASE_W-1:0] origin_base_reg, origin_base_next;
    logic [StrW-1:0]   stride_reg, stride_next;
    logic signed [PosW-1:0] ysum_reg, ysum_next;
    logic [1:0]        reload_cnt_reg, reload_cnt_next;

    // Input stage
    logic                   s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0]       s1_pix_reg;
    logic signed [PosW-1:0] s1_x_reg;
    logic signed [PosW-1:0] s1_y_reg;
    logic [BASE_W-1:0]      s1_base_reg;

    // Result stage
    logic      out_valid_reg, out_valid_next;
    fb_write_t out_data_reg;

    // Derived configuration
    logic [DEPTH_W-1:0] depth;
    logic [PIX_W-1:0]   byte_mask;
    logic [ScrW-1:0]    scr_w_eff;
    logic [ScrW-1:0]    scr_h_eff;
    logic [CntW-1:0]    spr_w_cnt;
    logic [CntW-1:0]    col_inc;

    logic                   cfg_fire;
    logic                   in_fire;
    logic                   advance;
    logic                   s1_free;
    logic                   on_screen;
    logic                   keyed;
    logic                   emit;
    logic [XoffW-1:0]       xoff;
    logic [BASE_W-1:0]      addr_sum;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [ProdW-1:0] prod_row;
    logic signed [ProdW-1:0] prod_origin;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Clamp depth to 1..4 and build the byte mask it selects
    always_comb
    begin
        if (bytes_per_pixel_reg == '0)
            depth = DEPTH_MIN;
        else if (bytes_per_pixel_reg > DEPTH_MAX)
            depth = DEPTH_MAX;
        else
            depth = bytes_per_pixel_reg;
        case (depth)
            3'd1:    byte_mask = 32'h0000_00FF;
            3'd2:    byte_mask = 32'h0000_FFFF;
            3'd3:    byte_mask = 32'h00FF_FFFF;
            default: byte_mask = 32'hFFFF_FFFF;
        endcase
    end

    // Saturate screen dimensions to the largest supported screen
    always_comb
    begin
        if (CmpW'(screen_width_reg) > CmpW'(MAX_SCREEN_DIM))
            scr_w_eff = ScrW'(MAX_SCREEN_DIM);
        else
            scr_w_eff = ScrW'(screen_width_reg);
        if (CmpW'(screen_height_reg) > CmpW'(MAX_SCREEN_DIM))
            scr_h_eff = ScrW'(MAX_SCREEN_DIM);
        else
            scr_h_eff = ScrW'(screen_height_reg);
    end

    assign spr_w_cnt = CntW'(sprite_width_reg);
    assign col_inc   = col_reg + CntW'(1);

    // Screen position of the pixel being taken
    assign pos_x = PosW'(origin_x_reg) + PosW'($signed({1'b0, col_reg}));
    assign pos_y = PosW'(origin_y_reg) + PosW'($signed({1'b0, row_reg}));

    // Clip, key and address for the pixel in the input stage
    assign on_screen = !s1_x_reg[PosW-1] && !s1_y_reg[PosW-1]
                       && (CmpW'($unsigned(s1_x_reg)) < CmpW'(scr_w_eff))
                       && (CmpW'($unsigned(s1_y_reg)) < CmpW'(scr_h_eff));
    assign keyed     = key_enable_reg && ((s1_pix_reg & byte_mask) == (key_color_reg & byte_mask));
    assign emit      = s1_valid_reg && on_screen && !keyed;
    assign xoff      = XoffW'($unsigned(s1_x_reg)) * XoffW'(depth);
    assign addr_sum  = s1_base_reg + BASE_W'(xoff);

    // Flow control: the result register frees when empty or taken; the input
    // stage frees when empty, when the result register can take it or when it makes no write
    assign advance  = !out_valid_reg || !out_stall;
    assign s1_free  = !s1_valid_reg || advance || !emit;
    assign in_stall = !s1_free || (reload_cnt_reg != 2'd0);
    assign in_fire  = in_valid && !in_stall;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_free);
    assign out_valid_next = advance ? emit : out_valid_reg;

    // Reload products: base of the current row and of the bitmap's first row
    assign prod_row    = ProdW'(ysum_reg) * ProdW'($signed({1'b0, stride_reg}));
    assign prod_origin = ProdW'(origin_y_reg) * ProdW'($signed({1'b0, stride_reg}));

    // Position counters and the reload sequence
    always_comb
    begin
        col_next         = col_reg;
        row_next         = row_reg;
        row_base_next    = row_base_reg;
        origin_base_next = origin_base_reg;
        stride_next      = stride_reg;
        ysum_next        = ysum_reg;
        reload_cnt_next  = reload_cnt_reg;

        if (in_fire)
        begin
            if (in_data.last_pixel)
            begin
                col_next      = '0;
                row_next      = '0;
                row_base_next = origin_base_reg;
            end
            else if (col_inc == spr_w_cnt)
            begin
                col_next      = '0;
                row_next      = row_reg + CntW'(1);
                row_base_next = row_base_reg + BASE_W'(stride_reg);
            end
            else
            begin
                col_next = col_inc;
            end
        end

        if (cfg_fire)
        begin
            reload_cnt_next = 2'd2;
        end
        else if (reload_cnt_reg == 2'd2)
        begin
            // Stride from the new screen width and depth, row sum from the new origin
            stride_next     = StrW'(scr_w_eff) * StrW'(depth);
            ysum_next       = pos_y;
            reload_cnt_next = 2'd1;
        end
        else if (reload_cnt_reg == 2'd1)
        begin
            row_base_next    = prod_row[BASE_W-1:0];
            origin_base_next = prod_origin[BASE_W-1:0];
            reload_cnt_next  = 2'd0;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg        <= '0;
            origin_y_reg        <= '0;
            sprite_width_reg    <= RST_SPRITE_WIDTH;
            screen_width_reg    <= RST_SCREEN_WIDTH;
            screen_height_reg   <= RST_SCREEN_HEIGHT;
            bytes_per_pixel_reg <= RST_BYTES_PER_PIX;
            key_color_reg       <= '0;
            key_enable_reg      <= 1'b1;
            col_reg             <= '0;
            row_reg             <= '0;
            row_base_reg        <= '0;
            origin_base_reg     <= '0;
            stride_reg          <= StrW'(RST_SCREEN_WIDTH) * StrW'(RST_BYTES_PER_PIX);
            ysum_reg            <= '0;
            reload_cnt_reg      <= 2'd0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_ORIGIN_X:        origin_x_reg        <= cfg_data[COORD_W-1:0];
                    CFG_ORIGIN_Y:        origin_y_reg        <= cfg_data[COORD_W-1:0];
                    CFG_SPRITE_WIDTH:    sprite_width_reg    <= cfg_data[SPRW_W-1:0];
                    CFG_SCREEN_WIDTH:    screen_width_reg    <= cfg_data[COORD_W-1:0];
                    CFG_SCREEN_HEIGHT:   screen_height_reg   <= cfg_data[COORD_W-1:0];
                    CFG_BYTES_PER_PIXEL: bytes_per_pixel_reg <= cfg_data[DEPTH_W-1:0];
                    CFG_KEY_COLOR:       key_color_reg       <= cfg_data[PIX_W-1:0];
                    CFG_KEY_ENABLE:      key_enable_reg      <= cfg_data[0];
                    default:             key_enable_reg      <= key_enable_reg;
                endcase
            end
            col_reg         <= col_next;
            row_reg         <= row_next;
            row_base_reg    <= row_base_next;
            origin_base_reg <= origin_base_next;
            stride_reg      <= stride_next;
            ysum_reg        <= ysum_next;
            reload_cnt_reg  <= reload_cnt_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers: capture on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg  <= in_data.pixel_value;
            s1_x_reg    <= pos_x;
            s1_y_reg    <= pos_y;
            s1_base_reg <= row_base_reg;
        end
        if (advance && emit)
        begin
            out_data_reg.fb_byte_address <= addr_sum[ADDR_W-1:0];
            out_data_reg.write_data      <= s1_pix_reg & byte_mask;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A register write holds off pixels until the row base is rebuilt
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> in_stall ##1 in_stall)
        else $error("pixel taken during row base reload");

    // The last pixel rewinds the position to the bitmap origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.last_pixel && !cfg_fire) |=>
            (col_reg == '0) && (row_reg == '0) && (row_base_reg == origin_base_reg))
        else $error("position not rewound after last pixel");

    // Bytes above the pixel depth never reach the framebuffer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.write_data & ~byte_mask) == '0))
        else $error("write data carries bytes beyond pixel depth");

endmodule

// ===== tb/cursor_sprite_blit_unit_test.sv =====
// Self-checking testbench for the cursor sprite blit unit: stimulus, prediction and scoreboard.
module cursor_sprite_blit_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cspb_pkg::*;

    localparam int SCREEN_LIMIT   = 4096;
    localparam int SPRITE_LIMIT   = 64;
    localparam int BITS_PER_BYTE  = 8;
    localparam int RANDOM_PIXELS  = 850;
    localparam int PHASE_PIXELS   = 60;
    localparam int WRAP_RUN       = 140;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int CYCLE_LIMIT    = 200000;

    // ------------------------------------------------------------------
    // Block ports, every input known from time zero
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    pix_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    fb_write_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    cursor_sprite_blit_unit #(
        .MAX_SCREEN_DIM (SCREEN_LIMIT),
        .MAX_SPRITE_DIM (SPRITE_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the register file and the position counters.
    // Values match the block's reset defaults.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] set_origin_x        = '0;
    logic signed [COORD_W-1:0] set_origin_y        = '0;
    logic [SPRW_W-1:0]         set_sprite_width    = RST_SPRITE_WIDTH;
    logic [COORD_W-1:0]        set_screen_width    = RST_SCREEN_WIDTH;
    logic [COORD_W-1:0]        set_screen_height   = RST_SCREEN_HEIGHT;
    logic [DEPTH_W-1:0]        set_bytes_per_pixel = RST_BYTES_PER_PIX;
    logic [PIX_W-1:0]          set_key_color       = '0;
    logic                      set_key_enable      = 1'b1;

    logic [SPRW_W-1:0]         cur_column   = '0;
    logic [SPRW_W-1:0]         cur_row      = '0;
    logic [BASE_W-1:0]         cur_row_base = '0;

    pix_in_t   pending_pixels[$];   // pixels waiting for the driver
    fb_write_t expected_writes[$];  // framebuffer writes still owed by the block

    int  sender_idle_pct   = 13;
    int  receiver_idle_pct = 78;
    logic long_hold        = 1'b0;

    int  queued_pixels   = 0;
    int  pixels_accepted = 0;
    int  writes_checked  = 0;
    int  register_writes = 0;
    int  failures        = 0;
    int  cycle_count     = 0;

    // Out-of-range depth codes fold into 1..4
    function automatic int depth_bytes();
        if (set_bytes_per_pixel < DEPTH_MIN)
            return int'(DEPTH_MIN);
        if (set_bytes_per_pixel > DEPTH_MAX)
            return int'(DEPTH_MAX);
        return int'(set_bytes_per_pixel);
    endfunction

    // Screen sizes beyond the limit saturate
    function automatic int clip_dim(logic [COORD_W-1:0] dim);
        return (dim > SCREEN_LIMIT) ? SCREEN_LIMIT : int'(dim);
    endfunction

    function automatic logic [PIX_W-1:0] depth_mask();
        int d;
        d = depth_bytes();
        if (d == int'(DEPTH_MAX))
            return '1;
        return (32'd1 << (BITS_PER_BYTE * d)) - 32'd1;
    endfunction

    // Row base follows origin_y plus the current row; kept modulo 2^28
    function automatic void reload_row_base();
        longint row_y;
        longint offset;
        row_y        = longint'(set_origin_y) + longint'(cur_row);
        offset       = row_y * clip_dim(set_screen_width) * depth_bytes();
        cur_row_base = offset[BASE_W-1:0];
    endfunction

    function automatic void apply_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_ORIGIN_X:        set_origin_x        = value[COORD_W-1:0];
            CFG_ORIGIN_Y:        set_origin_y        = value[COORD_W-1:0];
            CFG_SPRITE_WIDTH:    set_sprite_width    = value[SPRW_W-1:0];
            CFG_SCREEN_WIDTH:    set_screen_width    = value[COORD_W-1:0];
            CFG_SCREEN_HEIGHT:   set_screen_height   = value[COORD_W-1:0];
            CFG_BYTES_PER_PIXEL: set_bytes_per_pixel = value[DEPTH_W-1:0];
            CFG_KEY_COLOR:       set_key_color       = value;
            CFG_KEY_ENABLE:      set_key_enable      = value[0];
            default:             ;
        endcase
        reload_row_base();
    endfunction

    // Work out the write (if any) caused by one pixel, then advance the position
    function automatic void predict_fb_write(pix_in_t px);
        int                d;
        int                w;
        int                h;
        int                x;
        int                y;
        logic [PIX_W-1:0]  mask;
        logic [BASE_W-1:0] sum;
        logic [SPRW_W-1:0] next_col;
        fb_write_t         wr;
        d    = depth_bytes();
        w    = clip_dim(set_screen_width);
        h    = clip_dim(set_screen_height);
        mask = depth_mask();
        x    = int'(set_origin_x) + int'(cur_column);
        y    = int'(set_origin_y) + int'(cur_row);
        if (x >= 0 && y >= 0 && x < w && y < h &&
            !(set_key_enable && ((px.pixel_value & mask) == (set_key_color & mask))))
        begin
            sum                = cur_row_base + BASE_W'(x * d);
            wr.fb_byte_address = sum[ADDR_W-1:0];
            wr.write_data      = px.pixel_value & mask;
            expected_writes.push_back(wr);
        end
        if (px.last_pixel)
        begin
            cur_column = '0;
            cur_row    = '0;
            reload_row_base();
        end
        else
        begin
            next_col = cur_column + 1'b1;
            // a sprite width of zero wraps at 128 columns
            if (next_col == set_sprite_width)
            begin
                cur_column   = '0;
                cur_row      = cur_row + 1'b1;
                cur_row_base = cur_row_base + BASE_W'(w * d);
            end
            else
                cur_column = next_col;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_pixel(logic [PIX_W-1:0] value, logic last);
        pix_in_t px;
        px.pixel_value = value;
        px.last_pixel  = last;
        pending_pixels.push_back(px);
        queued_pixels++;
    endfunction

    // Bias toward the key color so transparency shows up often; junk the unused bytes
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] raw;
        logic [PIX_W-1:0] mask;
        raw  = $urandom();
        mask = depth_mask();
        case ($urandom_range(0, 9))
            0, 1, 2: return (raw & ~mask) | (set_key_color & mask);
            3:       return set_key_color ^ (32'd1 << $urandom_range(0, 31));
            4:       return $urandom_range(0, 1) ? '1 : '0;
            default: return raw;
        endcase
    endfunction

    // One well-formed bitmap in raster order, last_pixel on its final pixel
    function automatic void queue_bitmap();
        int cols;
        int rows;
        cols = (set_sprite_width == 0) ? (1 << SPRW_W) : int'(set_sprite_width);
        rows = (cols > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        for (int i = 0; i < cols * rows; i++)
            queue_pixel(random_pixel(), i == cols * rows - 1);
    endfunction

    // Broken sequences: last_pixel dropped in anywhere
    function automatic void queue_noise();
        int len;
        len = $urandom_range(1, 20);
        repeat (len)
            queue_pixel(random_pixel(), $urandom_range(0, 7) == 0);
    endfunction

    function automatic logic [COORD_W-1:0] pick_screen_dim();
        case ($urandom_range(0, 9))
            0:       return COORD_W'($urandom());   // zero and oversize included
            1:       return COORD_W'(SCREEN_LIMIT);
            2:       return 13'd640;
            default: return COORD_W'($urandom_range(1, 48));
        endcase
    endfunction

    // Call on a clock edge; return on a clock edge once the reload stall is over
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, value);
        register_writes++;
        cfg_valid <= 1'b0;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Hold until every pixel is taken and every write has arrived, then let
    // pixels that make no write clear the pipeline
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || in_valid || expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic program_random_setup(bit single_column);
        logic [SPRW_W-1:0]  spr_w;
        logic [COORD_W-1:0] scr_w;
        logic [COORD_W-1:0] scr_h;
        logic [COORD_W-1:0] org_x;
        logic [COORD_W-1:0] org_y;
        logic [DEPTH_W-1:0] bpp;
        int                 spr;
        case ($urandom_range(0, 19))
            0:          spr_w = SPRW_W'($urandom_range(0, (1 << SPRW_W) - 1));
            1, 2, 3:    spr_w = SPRW_W'($urandom_range(9, SPRITE_LIMIT));
            default:    spr_w = SPRW_W'($urandom_range(1, 8));
        endcase
        if (single_column)
            spr_w = 7'd1;
        spr   = (spr_w == 0) ? (1 << SPRW_W) : int'(spr_w);
        scr_w = pick_screen_dim();
        scr_h = pick_screen_dim();
        // Mostly straddle the screen so clipping on every edge is hit
        if ($urandom_range(0, 4) == 0)
            org_x = COORD_W'($urandom());
        else
            org_x = COORD_W'($urandom_range(0, clip_dim(scr_w) + spr) - spr);
        if ($urandom_range(0, 4) == 0)
            org_y = COORD_W'($urandom());
        else
            org_y = COORD_W'($urandom_range(0, clip_dim(scr_h) + 6) - 6);
        if ($urandom_range(0, 3) == 0)
            bpp = DEPTH_W'($urandom_range(0, 7));
        else
            bpp = DEPTH_W'($urandom_range(1, 4));
        write_reg(CFG_ORIGIN_X, CFG_DATA_W'(org_x));
        write_reg(CFG_ORIGIN_Y, CFG_DATA_W'(org_y));
        write_reg(CFG_SPRITE_WIDTH, CFG_DATA_W'(spr_w));
        write_reg(CFG_SCREEN_WIDTH, CFG_DATA_W'(scr_w));
        write_reg(CFG_SCREEN_HEIGHT, CFG_DATA_W'(scr_h));
        write_reg(CFG_BYTES_PER_PIXEL, CFG_DATA_W'(bpp));
        write_reg(CFG_KEY_COLOR, $urandom());
        write_reg(CFG_KEY_ENABLE, CFG_DATA_W'($urandom_range(0, 3) != 0));
    endtask

    // ------------------------------------------------------------------
    // Pixel driver: hold a stalled transfer, otherwise advance or idle
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            predict_fb_write(in_data);
            pixels_accepted++;
        end
        if (!in_valid || !in_stall)
        begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                in_data  <= pending_pixels.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Write monitor: compare each transfer with the oldest expected write
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : fb_write_checker
        fb_write_t want;
        if (out_valid && !out_stall)
        begin
            writes_checked++;
            if (expected_writes.size() == 0)
            begin
                $error("unexpected framebuffer write: fb_byte_address %h write_data %h",
                       out_data.fb_byte_address, out_data.write_data);
                failures++;
            end
            else
            begin
                want = expected_writes.pop_front();
                if (out_data.fb_byte_address !== want.fb_byte_address)
                begin
                    $error("fb_byte_address expected %h actual %h",
                           want.fb_byte_address, out_data.fb_byte_address);
                    failures++;
                end
                if (out_data.write_data !== want.write_data)
                begin
                    $error("write_data expected %h actual %h",
                           want.write_data, out_data.write_data);
                    failures++;
                end
            end
        end
        out_stall <= long_hold || ($urandom_range(0, 99) < receiver_idle_pct);
    end

    // Long receiver hold-offs while pixels keep coming: fills the block and
    // pushes back on its input. The second one lands in the no-idle stretch.
    initial
    begin : receiver_hold_off
        wait (pixels_accepted >= 120);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        long_hold <= 1'b0;
        wait (pixels_accepted >= 700);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL cursor_sprite_blit_unit");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int phase_no;
        int phase_start;
        int directed_count;
        int progress;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Narrow sprite on the default screen: key hits in the low byte only,
        // row ends, then an origin move partway down the bitmap
        write_reg(CFG_SPRITE_WIDTH, 32'd2);
        queue_pixel(32'h0000_0000, 1'b0);
        queue_pixel(32'hFFFF_FFFF, 1'b0);
        queue_pixel(32'h1234_5600, 1'b0);
        queue_pixel(32'h0000_00A5, 1'b0);
        queue_pixel(32'h0000_0080, 1'b0);
        wait_idle();
        write_reg(CFG_ORIGIN_Y, 32'd3);
        queue_pixel(32'h0000_007F, 1'b1);
        wait_idle();

        // Right edge of an oversize screen, deepest depth code, clipped on
        // top, right and bottom
        write_reg(CFG_ORIGIN_X, 32'd4094);
        write_reg(CFG_ORIGIN_Y, 32'h0000_1FFF);
        write_reg(CFG_SPRITE_WIDTH, 32'd3);
        write_reg(CFG_SCREEN_WIDTH, 32'h0000_1FFF);
        write_reg(CFG_SCREEN_HEIGHT, 32'd1);
        write_reg(CFG_BYTES_PER_PIXEL, 32'd7);
        write_reg(CFG_KEY_COLOR, 32'hDEAD_BEEF);
        write_reg(CFG_KEY_ENABLE, 32'd1);
        queue_pixel(32'hFFFF_FFFF, 1'b0);
        queue_pixel(32'h0000_0000, 1'b0);
        queue_pixel(32'h0000_0001, 1'b0);
        queue_pixel(32'hFFFF_FFFF, 1'b0);
        queue_pixel(32'hDEAD_BEEF, 1'b0);
        queue_pixel(32'h1234_5678, 1'b0);
        queue_pixel(32'h55AA_55AA, 1'b0);
        queue_pixel(32'hAA55_AA55, 1'b0);
        queue_pixel(32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // Zero-width screen draws nothing; most negative origin, depth code zero
        write_reg(CFG_ORIGIN_X, 32'h0000_1000);
        write_reg(CFG_SPRITE_WIDTH, 32'd2);
        write_reg(CFG_SCREEN_WIDTH, 32'd0);
        write_reg(CFG_BYTES_PER_PIXEL, 32'd0);
        write_reg(CFG_KEY_ENABLE, 32'd0);
        queue_pixel(32'h0000_0000, 1'b0);
        queue_pixel(32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // Bottom row of a full-height screen with keying off, first pixel clipped on the left
        write_reg(CFG_ORIGIN_X, 32'h0000_1FFF);
        write_reg(CFG_ORIGIN_Y, 32'd4095);
        write_reg(CFG_SCREEN_WIDTH, 32'd3);
        write_reg(CFG_SCREEN_HEIGHT, 32'd4096);
        queue_pixel(32'h0000_0000, 1'b0);
        queue_pixel(32'h0000_0000, 1'b1);
        wait_idle();

        // Random phases: new register set each phase, mostly whole bitmaps
        directed_count = queued_pixels;
        phase_no       = 0;
        while (queued_pixels - directed_count < RANDOM_PIXELS)
        begin
            progress = queued_pixels - directed_count;
            if (progress < RANDOM_PIXELS / 3)
            begin
                sender_idle_pct   = 13;
                receiver_idle_pct = 78;
            end
            else if (progress < 2 * RANDOM_PIXELS / 3)
            begin
                sender_idle_pct   = 78;
                receiver_idle_pct = 13;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            program_random_setup(phase_no == 3);
            // Usually realign to the first pixel; otherwise carry the old position
            if (phase_no == 3 || $urandom_range(0, 3) != 0)
                queue_pixel(random_pixel(), 1'b1);
            phase_start = queued_pixels;
            if (phase_no == 3)
            begin
                // One-column sprite with no end mark: the row counter wraps
                repeat (WRAP_RUN)
                    queue_pixel(random_pixel(), 1'b0);
            end
            else
            begin
                while (queued_pixels - phase_start < PHASE_PIXELS)
                begin
                    if ($urandom_range(0, 4) != 0)
                        queue_bitmap();
                    else
                        queue_noise();
                end
            end
            wait_idle();
            phase_no++;
        end

        $display("Run covered %0d pixel transfers, %0d framebuffer writes checked,",
                 pixels_accepted, writes_checked);
        $display("  %0d register writes over %0d random register sets plus directed cases",
                 register_writes, phase_no);
        if (failures == 0)
            $display("PASS cursor_sprite_blit_unit");
        else
            $display("FAIL cursor_sprite_blit_unit");
        $finish;
    end

endmodule
